/* hdl/trilinear_voxel_sampler_macros.svh */
// assertion helpers, all clocked on clk and disabled while rst_n is low
`ifndef TRILINEAR_VOXEL_SAMPLER_MACROS_SVH
`define TRILINEAR_VOXEL_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TVS_ASSERT_IMPL(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define TVS_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define TVS_ASSERT_IMPL(name, cond, prop)
`define TVS_ASSERT_NEXT(name, cond, prop)
`endif
`endif

/* hdl/tvs_pkg.sv */
`timescale 1ns / 1ps
package tvs_pkg;

  localparam int DEF_MAX_X     = 64;
  localparam int DEF_MAX_Y     = 64;
  localparam int DEF_MAX_Z     = 32;
  localparam int DEF_FRAC_BITS = 8;

  // stream layout
  localparam int IN_TDATA_W   = 88;
  localparam int OUT_TDATA_W  = 24;
  localparam int COORD_W      = 17;
  localparam int WADDR_W      = 17;
  localparam int VOXEL_W      = 16;
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_VALUE_LSB = 17;
  localparam int IN_CX_LSB    = 33;
  localparam int IN_CY_LSB    = 50;
  localparam int IN_CZ_LSB    = 67;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_MODE = 3'd4;

  localparam int RST_SIZE_X = 64;
  localparam int RST_SIZE_Y = 64;
  localparam int RST_SIZE_Z = 32;

  // command kinds carried from front to back
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [1:0] KIND_OUTSIDE = 2'd2;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [6:0]  sx;
    logic [6:0]  sy;
    logic [5:0]  sz;
    logic [13:0] sxsy;
    logic [15:0] background;
    logic        mode;
  } tvs_cfg_t;

  typedef struct packed {
    logic busy;
    logic pipe_active;
  } tvs_back_stat_t;

  function automatic logic [6:0] clamp_size(input logic [6:0] s, input int m);
    return (int'(s) > m) ? 7'(m) : s;
  endfunction

  // kind, address, write data, ceiling steps, three fractions
  function automatic int q_width(input int aw, input int fb);
    return 2 + aw + VOXEL_W + 3 + 3 * fb;
  endfunction

endpackage

/* hdl/tvs_queue.sv */
`timescale 1ns / 1ps
module tvs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_vld,
  output logic         in_rdy,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  input  logic         out_rdy,
  output logic [W-1:0] out_data
);

  localparam int PW = $clog2(tvs_pkg::QDEPTH);

  logic [W-1:0]  slot_r [tvs_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          push, pop;

  always_comb begin
    in_rdy   = count_r != (PW+1)'(tvs_pkg::QDEPTH);
    out_vld  = count_r != '0;
    out_data = slot_r[rd_ptr_r];
    push     = in_vld && in_rdy;
    pop      = out_vld && out_rdy;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(tvs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(tvs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

/* hdl/tvs_front.sv */
`timescale 1ns / 1ps
module tvs_front #(
  parameter int FRAC_BITS = tvs_pkg::DEF_FRAC_BITS,
  parameter int VOL_DEPTH = tvs_pkg::DEF_MAX_X * tvs_pkg::DEF_MAX_Y * tvs_pkg::DEF_MAX_Z,
  parameter int AW        = $clog2(VOL_DEPTH)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  tvs_pkg::tvs_cfg_t                           cfg,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [tvs_pkg::IN_TDATA_W-1:0]              in_tdata,
  input  logic                                        in_tuser,
  output logic                                        q_vld,
  input  logic                                        q_rdy,
  output logic [tvs_pkg::q_width(AW, FRAC_BITS)-1:0]  q_data
);

  typedef struct packed {
    logic [1:0]                kind;
    logic [AW-1:0]             addr;
    logic [15:0]               data;
    logic [2:0]                step;
    logic [2:0][FRAC_BITS-1:0] frac;
  } q_entry_t;

  logic [2:0][16:0]          coord;
  logic [2:0][15:0]          fmag;
  logic [2:0][FRAC_BITS-1:0] frac;
  logic [2:0]                step;
  logic [2:0][16:0]          ceil_v;
  logic                      outside;
  logic [16:0]               wr_addr;
  logic [15:0]               wr_raw;
  logic [15:0]               wr_val;
  logic                      wr_ok;
  logic [13:0]               prod_y;
  logic [19:0]               prod_z;
  logic                      accept;
  logic                      s1_take;

  logic                      s1_vld_r, s1_vld_nxt;
  logic [1:0]                s1_kind_r;
  logic                      s1_drop_r;
  logic [16:0]               s1_addr_r;
  logic [15:0]               s1_wval_r;
  logic [6:0]                s1_fx_r;
  logic [13:0]               s1_py_r;
  logic [19:0]               s1_pz_r;
  logic [2:0][FRAC_BITS-1:0] s1_frac_r;
  logic [2:0]                s1_step_r;

  logic [31:0]               base32;
  logic [31:0]               wa32;
  q_entry_t                  entry;

  assign coord[0] = in_tdata[tvs_pkg::IN_CX_LSB +: tvs_pkg::COORD_W];
  assign coord[1] = in_tdata[tvs_pkg::IN_CY_LSB +: tvs_pkg::COORD_W];
  assign coord[2] = in_tdata[tvs_pkg::IN_CZ_LSB +: tvs_pkg::COORD_W];
  assign wr_addr  = in_tdata[tvs_pkg::IN_ADDR_LSB +: tvs_pkg::WADDR_W];
  assign wr_raw   = in_tdata[tvs_pkg::IN_VALUE_LSB +: tvs_pkg::VOXEL_W];

  // floor is the low 16 bits shifted right; a set sign bit means a negative, outside point
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fmag[a]   = 16'(coord[a][15:0] >> FRAC_BITS);
      frac[a]   = coord[a][FRAC_BITS-1:0];
      step[a]   = |frac[a];
      ceil_v[a] = {1'b0, fmag[a]} + 17'(step[a]);
    end
    outside = coord[0][16] | coord[1][16] | coord[2][16] |
              (ceil_v[0] >= 17'(cfg.sx)) | (ceil_v[1] >= 17'(cfg.sy)) |
              (ceil_v[2] >= 17'(cfg.sz));
    wr_ok  = 32'(wr_addr) < 32'(VOL_DEPTH);
    wr_val = cfg.mode ? wr_raw : {8'h00, wr_raw[7:0]};
    // only meaningful for points inside, where indices fit the size fields
    prod_y = 14'(cfg.sx) * 14'(fmag[1][6:0]);
    prod_z = 20'(cfg.sxsy) * 20'(fmag[2][5:0]);
  end

  // an out-of-range write leaves the stage without a queue transfer
  assign s1_take   = !s1_vld_r || s1_drop_r || q_rdy;
  assign in_tready = s1_take;
  assign accept    = in_tvalid && in_tready;
  assign q_vld     = s1_vld_r && !s1_drop_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_take) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= !in_tuser ? tvs_pkg::KIND_WRITE :
                   (outside ? tvs_pkg::KIND_OUTSIDE : tvs_pkg::KIND_SAMPLE);
      s1_drop_r <= !in_tuser && !wr_ok;
      s1_addr_r <= wr_addr;
      s1_wval_r <= wr_val;
      s1_fx_r   <= fmag[0][6:0];
      s1_py_r   <= prod_y;
      s1_pz_r   <= prod_z;
      s1_frac_r <= frac;
      s1_step_r <= step;
    end
  end

  always_comb begin
    base32     = 32'(s1_fx_r) + 32'(s1_py_r) + 32'(s1_pz_r);
    wa32       = 32'(s1_addr_r);
    entry.kind = s1_kind_r;
    entry.addr = (s1_kind_r == tvs_pkg::KIND_WRITE) ? wa32[AW-1:0] : base32[AW-1:0];
    entry.data = s1_wval_r;
    entry.step = s1_step_r;
    entry.frac = s1_frac_r;
  end

  assign q_data = entry;

endmodule

/* hdl/tvs_back.sv */
`timescale 1ns / 1ps
module tvs_back #(
  parameter int FRAC_BITS = tvs_pkg::DEF_FRAC_BITS,
  parameter int VOL_DEPTH = tvs_pkg::DEF_MAX_X * tvs_pkg::DEF_MAX_Y * tvs_pkg::DEF_MAX_Z,
  parameter int AW        = $clog2(VOL_DEPTH)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  tvs_pkg::tvs_cfg_t                           cfg,
  input  logic                                        q_vld,
  output logic                                        q_rdy,
  input  logic [tvs_pkg::q_width(AW, FRAC_BITS)-1:0]  q_data,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [tvs_pkg::OUT_TDATA_W-1:0]             out_tdata,
  output logic                                        out_tuser,
  output tvs_pkg::tvs_back_stat_t                     stat
);

  typedef struct packed {
    logic [1:0]                kind;
    logic [AW-1:0]             addr;
    logic [15:0]               data;
    logic [2:0]                step;
    logic [2:0][FRAC_BITS-1:0] frac;
  } q_entry_t;

  localparam int WXY_W  = 2 * FRAC_BITS + 2;
  localparam int W_W    = 3 * FRAC_BITS + 3;
  localparam int PROD_W = W_W + 16;
  localparam int ACC_W  = (PROD_W > 2 * FRAC_BITS + 24) ? PROD_W : 2 * FRAC_BITS + 24;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

  logic [15:0] vol_mem [VOL_DEPTH];

  q_entry_t                  e;
  logic                      out_free;
  logic                      pop;
  logic                      pipe_busy;
  logic                      issue;
  logic                      mem_we;
  logic                      start;
  logic                      load_res;
  logic                      load_bg;
  logic [2:0][FRAC_BITS:0]   wsel;
  logic [31:0]               raddr32;
  logic [15:0]               rd_voxel;
  logic [31:0]               bg32;

  logic [1:0]                st_r, st_nxt;
  logic [2:0]                k_r, k_nxt;
  logic                      p1_vld_r, p2_vld_r, p3_vld_r;
  logic                      out_vld_r, out_vld_nxt;

  logic [AW-1:0]             base_r;
  logic [6:0]                offy_r;
  logic [13:0]               offz_r;
  logic [2:0]                step_r;
  logic [2:0][FRAC_BITS-1:0] frac_r;
  logic [15:0]               rdata_r;
  logic [WXY_W-1:0]          wxy_r;
  logic [FRAC_BITS:0]        wz_r;
  logic [15:0]               v_r;
  logic [W_W-1:0]            w_r;
  logic [PROD_W-1:0]         prod_r;
  logic [ACC_W-1:0]          acc_r;
  logic [23:0]               out_data_r;
  logic                      out_flag_r;

  assign e = q_data;

  always_comb begin
    out_free  = !out_vld_r || out_tready;
    pipe_busy = p1_vld_r || p2_vld_r || p3_vld_r;
    q_rdy     = 1'b0;
    if (st_r == ST_IDLE) begin
      case (e.kind)
        tvs_pkg::KIND_OUTSIDE: q_rdy = out_free;
        default:               q_rdy = 1'b1;
      endcase
    end
    pop = q_vld && q_rdy;

    st_nxt   = st_r;
    k_nxt    = k_r;
    mem_we   = 1'b0;
    start    = 1'b0;
    load_res = 1'b0;
    load_bg  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (pop) begin
          case (e.kind)
            tvs_pkg::KIND_WRITE:   mem_we = 1'b1;
            tvs_pkg::KIND_SAMPLE: begin
              start  = 1'b1;
              k_nxt  = '0;
              st_nxt = ST_RUN;
            end
            tvs_pkg::KIND_OUTSIDE: load_bg = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy && out_free) begin
          load_res = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    issue = st_r == ST_RUN;

    out_vld_nxt = out_vld_r;
    if (load_res || load_bg) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // corner k: bit 0 picks the x ceiling, bit 1 y, bit 2 z
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wsel[a] = k_r[a] ? {1'b0, frac_r[a]} : ONE_FRAC - {1'b0, frac_r[a]};
    end
    raddr32 = 32'(base_r) + 32'(k_r[0] & step_r[0]) +
              (k_r[1] ? 32'(offy_r) : 32'd0) + (k_r[2] ? 32'(offz_r) : 32'd0);
    rd_voxel = cfg.mode ? rdata_r : {8'h00, rdata_r[7:0]};
    bg32     = 32'(cfg.background) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vol_mem[e.addr] <= e.data;
    end
    rdata_r <= vol_mem[raddr32[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      k_r       <= '0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      k_r       <= k_nxt;
      p1_vld_r  <= issue;
      p2_vld_r  <= p1_vld_r;
      p3_vld_r  <= p2_vld_r;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_r <= e.addr;
      offy_r <= e.step[1] ? cfg.sx : 7'd0;
      offz_r <= e.step[2] ? cfg.sxsy : 14'd0;
      step_r <= e.step;
      frac_r <= e.frac;
      acc_r  <= '0;
    end
    if (issue) begin
      wxy_r <= WXY_W'(wsel[0]) * WXY_W'(wsel[1]);
      wz_r  <= wsel[2];
    end
    if (p1_vld_r) begin
      v_r <= rd_voxel;
      w_r <= W_W'(wxy_r) * W_W'(wz_r);
    end
    if (p2_vld_r) begin
      prod_r <= PROD_W'(v_r) * PROD_W'(w_r);
    end
    if (p3_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (load_res) begin
      out_data_r <= acc_r[2*FRAC_BITS +: 24];
      out_flag_r <= 1'b0;
    end else if (load_bg) begin
      out_data_r <= bg32[23:0];
      out_flag_r <= 1'b1;
    end
  end

  assign out_tvalid       = out_vld_r;
  assign out_tdata        = out_data_r;
  assign out_tuser        = out_flag_r;
  assign stat.busy        = st_r != ST_IDLE;
  assign stat.pipe_active = pipe_busy;

endmodule

/* hdl/trilinear_voxel_sampler.sv */
// Trilinear voxel sampler. A write transfer (tuser 0) stores one voxel into the on-chip
// volume memory of MAX_X*MAX_Y*MAX_Z 16-bit words; it produces no result. A sample
// transfer (tuser 1) gives one result: the trilinear interpolation of the eight corners
// around a signed Q9.8 point, or the background value shifted by the fraction width with
// the outside flag set. An inside sample is taken from the queue, then makes eight corner
// reads through the volume memory's one read port, one per cycle, then empties the weight
// and multiply-accumulate pipeline and loads the result once the output is free; an
// outside sample is taken only when the output is free. The front stage and a four-entry
// command queue keep taking input while a sample runs, until the queue is full. The memory
// is not cleared by reset, so voxels must be written before they are sampled. Size values
// above the built maximum (low seven bits, low six for z) act as that maximum.
`timescale 1ns / 1ps
`include "trilinear_voxel_sampler_macros.svh"
module trilinear_voxel_sampler #(
  parameter int MAX_X     = tvs_pkg::DEF_MAX_X,
  parameter int MAX_Y     = tvs_pkg::DEF_MAX_Y,
  parameter int MAX_Z     = tvs_pkg::DEF_MAX_Z,
  parameter int FRAC_BITS = tvs_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // voxel_addr[16:0], voxel_value[32:17], coord_x[49:33], coord_y[66:50], coord_z[83:67]
  input  logic [tvs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sample_value[23:0]
  output logic [tvs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // outside[0]
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [tvs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VOL_DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW        = $clog2(VOL_DEPTH);
  localparam int QW        = tvs_pkg::q_width(AW, FRAC_BITS);

  localparam logic [6:0] RST_SX = tvs_pkg::clamp_size(7'(tvs_pkg::RST_SIZE_X), MAX_X);
  localparam logic [6:0] RST_SY = tvs_pkg::clamp_size(7'(tvs_pkg::RST_SIZE_Y), MAX_Y);
  localparam logic [6:0] RST_SZ = tvs_pkg::clamp_size(7'(tvs_pkg::RST_SIZE_Z), MAX_Z);

  tvs_pkg::tvs_cfg_t       cfg_r, cfg_nxt;
  tvs_pkg::tvs_back_stat_t bstat;

  logic          fq_vld, fq_rdy;
  logic [QW-1:0] fq_data;
  logic          qb_vld, qb_rdy;
  logic [QW-1:0] qb_data;

  assign cfg_ready = 1'b1;

  // sizes are stored already clamped, along with the x*y slice area
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        tvs_pkg::CFG_SIZE_X: begin
          cfg_nxt.sx   = tvs_pkg::clamp_size(cfg_data[6:0], MAX_X);
          cfg_nxt.sxsy = 14'(cfg_nxt.sx) * 14'(cfg_r.sy);
        end
        tvs_pkg::CFG_SIZE_Y: begin
          cfg_nxt.sy   = tvs_pkg::clamp_size(cfg_data[6:0], MAX_Y);
          cfg_nxt.sxsy = 14'(cfg_r.sx) * 14'(cfg_nxt.sy);
        end
        tvs_pkg::CFG_SIZE_Z:     cfg_nxt.sz = 6'(tvs_pkg::clamp_size({1'b0, cfg_data[5:0]}, MAX_Z));
        tvs_pkg::CFG_BACKGROUND: cfg_nxt.background = cfg_data;
        tvs_pkg::CFG_VOXEL_MODE: cfg_nxt.mode = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx         <= RST_SX;
      cfg_r.sy         <= RST_SY;
      cfg_r.sz         <= 6'(RST_SZ);
      cfg_r.sxsy       <= 14'(RST_SX) * 14'(RST_SY);
      cfg_r.background <= '0;
      cfg_r.mode       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tvs_front #(
    .FRAC_BITS (FRAC_BITS),
    .VOL_DEPTH (VOL_DEPTH),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_vld     (fq_vld),
    .q_rdy     (fq_rdy),
    .q_data    (fq_data)
  );

  tvs_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fq_vld),
    .in_rdy   (fq_rdy),
    .in_data  (fq_data),
    .out_vld  (qb_vld),
    .out_rdy  (qb_rdy),
    .out_data (qb_data)
  );

  tvs_back #(
    .FRAC_BITS (FRAC_BITS),
    .VOL_DEPTH (VOL_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_vld      (qb_vld),
    .q_rdy      (qb_rdy),
    .q_data     (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (bstat)
  );

  // a command refused by the queue is offered again unchanged
  `TVS_ASSERT_NEXT(a_front_holds, fq_vld && !fq_rdy, fq_vld && $stable(fq_data))
  // no command leaves the queue while a sample is in progress
  `TVS_ASSERT_IMPL(a_no_pop_busy, bstat.busy, !(qb_vld && qb_rdy))
  // the multiply-accumulate pipeline only runs inside a sample
  `TVS_ASSERT_IMPL(a_pipe_in_sample, bstat.pipe_active, bstat.busy)

endmodule
